[rtl/cavn_pkg.sv]
`default_nettype none
package cavn_pkg;

  localparam int VERTS      = 4096;
  localparam int FACES      = 4096;
  localparam int VIDX_W     = 12;
  localparam int FIDX_W     = 12;
  localparam int POS_W      = 16;
  localparam int NRM_W      = 16;
  localparam int WIDE_W     = 36;
  localparam int SUM_W      = 30;
  localparam int FCNT_W     = 13;
  localparam int CFG_DATA_W = 16;

  localparam logic [1:0] OP_LOAD_VERTEX = 2'd0;
  localparam logic [1:0] OP_LOAD_FACE   = 2'd1;
  localparam logic [1:0] OP_QUERY       = 2'd2;

  localparam logic REG_FACE_COUNT = 1'b0;
  localparam logic REG_CREASE     = 1'b1;

  localparam logic [CFG_DATA_W-1:0] CREASE_RESET = 16'd8192;

  typedef struct packed {
    logic [1:0]              operation;
    logic [VIDX_W-1:0]       vertex_index;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [FIDX_W-1:0]       face_index;
    logic [VIDX_W-1:0]       corner_a;
    logic [VIDX_W-1:0]       corner_b;
    logic [VIDX_W-1:0]       corner_c;
  } in_item_t;

  typedef struct packed {
    logic signed [NRM_W-1:0] normal_x;
    logic signed [NRM_W-1:0] normal_y;
    logic signed [NRM_W-1:0] normal_z;
    logic [FIDX_W-1:0]       queried_face;
    logic [1:0]              corner_number;
    logic                    last;
  } out_item_t;

  typedef logic [2:0][WIDE_W-1:0] wide_vec_t;
  typedef logic [2:0][NRM_W-1:0]  nrm_vec_t;
  typedef logic [2:0][POS_W-1:0]  pos_vec_t;
  typedef logic [2:0][VIDX_W-1:0] corner_vec_t;

  typedef struct packed {
    logic busy;
    logic done;
  } norm_stat_t;

endpackage
`default_nettype wire

[rtl/cavn_if.sv]
`default_nettype none
interface cavn_in_if;
  import cavn_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface cavn_out_if;
  import cavn_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[rtl/cavn_norm.sv]
`default_nettype none
// Iterative vector normalizer: pre-shift, sum of squares through one
// multiplier, bit-serial square root, then one restoring divide per component.
module cavn_norm (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  cavn_pkg::wide_vec_t    vin,
  output cavn_pkg::norm_stat_t   stat,
  output cavn_pkg::nrm_vec_t     vout
);
  import cavn_pkg::*;

  localparam logic [2:0] N_IDLE  = 3'd0;
  localparam logic [2:0] N_SHIFT = 3'd1;
  localparam logic [2:0] N_SQ    = 3'd2;
  localparam logic [2:0] N_SQRT  = 3'd3;
  localparam logic [2:0] N_DLOAD = 3'd4;
  localparam logic [2:0] N_DIV   = 3'd5;

  logic [2:0]        state;
  logic              done;
  logic [WIDE_W-1:0] mag [3];
  logic [2:0]        neg;
  logic [4:0]        cnt;
  logic [1:0]        ci;
  logic [59:0]       prod;
  logic [61:0]       sq;
  logic [61:0]       sq_acc;
  logic [61:0]       sh;
  logic [30:0]       root;
  logic [32:0]       rem;
  logic [34:0]       rem_sh;
  logic [34:0]       trial;
  logic [15:0]       num16;
  logic [31:0]       drem;
  logic [32:0]       drem_sh;
  logic [32:0]       dvs;
  logic              q_bit;
  logic [15:0]       quo;
  logic [15:0]       q_fin;
  logic [45:0]       num_init;
  logic [29:0]       sq_op;
  logic [59:0]       sq_term;
  logic [NRM_W-1:0]  res [3];
  logic              big;

  always_comb begin
    sq_op    = (cnt[1:0] == 2'd3) ? '0 : mag[cnt[1:0]][29:0];
    sq_term  = sq_op * sq_op;
    sq_acc   = sq + {2'b0, prod};
    rem_sh   = {rem, sh[61:60]};
    trial    = {2'b0, root, 2'b01};
    dvs      = {1'b0, root, 1'b0};
    drem_sh  = {drem, num16[15]};
    q_bit    = (drem_sh >= dvs);
    q_fin    = {quo[14:0], q_bit};
    num_init = {1'b0, mag[ci][29:0], 15'b0} + {15'b0, root};
    big      = (|mag[0][WIDE_W-1:30]) | (|mag[1][WIDE_W-1:30]) | (|mag[2][WIDE_W-1:30]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              neg[i] <= vin[i][WIDE_W-1];
              mag[i] <= vin[i][WIDE_W-1] ? WIDE_W'(0 - vin[i]) : vin[i];
            end
            state <= N_SHIFT;
          end
        end
        N_SHIFT: begin
          if (big) begin
            for (int i = 0; i < 3; i++) mag[i] <= mag[i] >> 1;
          end else begin
            cnt   <= '0;
            sq    <= '0;
            state <= N_SQ;
          end
        end
        N_SQ: begin
          prod <= sq_term;
          if (cnt != 5'd0) sq <= sq_acc;
          cnt <= cnt + 5'd1;
          if (cnt == 5'd3) begin
            sh    <= sq_acc;
            root  <= '0;
            rem   <= '0;
            cnt   <= '0;
            state <= N_SQRT;
          end
        end
        N_SQRT: begin
          sh <= sh << 2;
          if (rem_sh >= trial) begin
            rem  <= 33'(rem_sh - trial);
            root <= {root[29:0], 1'b1};
          end else begin
            rem  <= rem_sh[32:0];
            root <= {root[29:0], 1'b0};
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd30) begin
            ci    <= '0;
            state <= N_DLOAD;
          end
        end
        N_DLOAD: begin
          drem  <= {2'b0, num_init[45:16]};
          num16 <= num_init[15:0];
          quo   <= '0;
          cnt   <= '0;
          state <= N_DIV;
        end
        N_DIV: begin
          drem  <= q_bit ? 32'(drem_sh - dvs) : drem_sh[31:0];
          quo   <= q_fin;
          num16 <= num16 << 1;
          cnt   <= cnt + 5'd1;
          if (cnt == 5'd15) begin
            // A zero-length vector normalizes to zero.
            if (root == '0) res[ci] <= '0;
            else res[ci] <= neg[ci] ? NRM_W'(0 - q_fin) : q_fin;
            if (ci == 2'd2) begin
              done  <= 1'b1;
              state <= N_IDLE;
            end else begin
              ci    <= ci + 2'd1;
              state <= N_DLOAD;
            end
          end
        end
        default: state <= N_IDLE;
      endcase
    end
  end

  assign stat.busy = (state != N_IDLE);
  assign stat.done = done;
  assign vout[0]   = res[0];
  assign vout[1]   = res[1];
  assign vout[2]   = res[2];

endmodule
`default_nettype wire

[rtl/crease_angle_vertex_normals.sv]
`default_nettype none
// Crease-angle smoothed vertex normals. Requests of three kinds come in on
// in_ch: a vertex load writes one position; a face load reads its three
// vertices, forms the cross product with one shared 17x17 multiplier and
// normalizes it; a query scans the faces 0 to face_count-1 (at most 4096)
// once through the single read port of the face stores, one face per cycle,
// summing the normals of faces that share each corner's vertex and pass the
// crease test, then normalizes the three sums. The normalizer pre-shifts,
// squares, takes the square root and divides each component in turn. Three
// corner results come out on out_ch, corner 0 first, with last set on
// corner 2. The block takes no new request while it works on one. Stores
// are not cleared at reset, so a query must only touch vertices and faces
// that were loaded. Configuration registers must only be written while the
// block is idle.
module crease_angle_vertex_normals (
  input  logic                             clk,
  input  logic                             rst,
  cavn_in_if.sink                          in_ch,
  cavn_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [cavn_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cavn_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_VRD   = 4'd1;
  localparam logic [3:0] S_EDGE  = 4'd2;
  localparam logic [3:0] S_CROSS = 4'd3;
  localparam logic [3:0] S_FNORM = 4'd4;
  localparam logic [3:0] S_FWAIT = 4'd5;
  localparam logic [3:0] S_QHDR  = 4'd6;
  localparam logic [3:0] S_SCAN  = 4'd7;
  localparam logic [3:0] S_CNORM = 4'd8;
  localparam logic [3:0] S_CWAIT = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  // Configuration registers.
  logic [FCNT_W-1:0]     face_count;
  logic [CFG_DATA_W-1:0] crease;

  always_ff @(posedge clk) begin
    if (rst) begin
      face_count <= '0;
      crease     <= CREASE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FACE_COUNT: face_count <= cfg_data[FCNT_W-1:0];
        REG_CREASE:     crease     <= cfg_data;
      endcase
    end
  end

  logic [3:0]  state;
  logic [2:0]  cnt;
  logic [1:0]  corner;
  in_item_t    item;
  logic        accept;

  assign in_ch.ready = (state == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;

  // Normalizer.
  logic        nstart;
  wide_vec_t   nvin;
  norm_stat_t  nstat;
  nrm_vec_t    nvout;

  // Stores. Their contents are undefined until loaded.
  pos_vec_t    vmem [VERTS];
  corner_vec_t cmem [FACES];
  nrm_vec_t    nmem [FACES];
  pos_vec_t    vrd;
  corner_vec_t crd;
  nrm_vec_t    nrd;
  logic [VIDX_W-1:0] vaddr;
  logic [FIDX_W-1:0] faddr;
  logic              face_we;

  always_ff @(posedge clk) begin
    if (accept && in_ch.payload.operation == OP_LOAD_VERTEX) begin
      vmem[in_ch.payload.vertex_index] <=
        {in_ch.payload.pos_z, in_ch.payload.pos_y, in_ch.payload.pos_x};
    end
    vrd <= vmem[vaddr];
  end

  always_ff @(posedge clk) begin
    if (face_we) begin
      cmem[item.face_index] <= {item.corner_c, item.corner_b, item.corner_a};
      nmem[item.face_index] <= nvout;
    end
    crd <= cmem[faddr];
    nrd <= nmem[faddr];
  end

  // Face normal datapath.
  logic signed [POS_W:0]    e1 [3];
  logic signed [POS_W:0]    e2 [3];
  pos_vec_t                 pv [3];
  logic signed [POS_W:0]    ma;
  logic signed [POS_W:0]    mb;
  logic signed [2*POS_W+1:0] xprod;
  logic signed [WIDE_W-1:0] cr [3];
  logic [2:0]               cm1;

  // Query datapath.
  corner_vec_t              qc;
  nrm_vec_t                 qn;
  logic [FCNT_W-1:0]        k;
  logic [FCNT_W-1:0]        lim;
  logic                     issue;
  logic                     iv, pvld, av;
  logic [1:0]               occ1 [3];
  logic [1:0]               occ2 [3];
  nrm_vec_t                 nrm1;
  nrm_vec_t                 nrm2;
  logic signed [31:0]       dp [3];
  logic signed [33:0]       dot;
  logic signed [33:0]       thr;
  logic                     pass2;
  logic signed [SUM_W-1:0]  sums [3][3];

  cavn_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (nstart),
    .vin   (nvin),
    .stat  (nstat),
    .vout  (nvout)
  );

  function automatic logic signed [SUM_W-1:0] scale(input logic [1:0] occ,
                                                     input logic [NRM_W-1:0] v);
    logic signed [SUM_W-1:0] s;
    s = SUM_W'($signed(v));
    unique case (occ)
      2'd0: scale = '0;
      2'd1: scale = s;
      2'd2: scale = s <<< 1;
      2'd3: scale = s + (s <<< 1);
    endcase
  endfunction

  always_comb begin
    lim   = (face_count > FCNT_W'(FACES)) ? FCNT_W'(FACES) : face_count;
    issue = (state == S_SCAN) && (k < lim);
    thr   = {{4{crease[15]}}, crease, 14'b0};
    dot   = 34'(dp[0]) + 34'(dp[1]) + 34'(dp[2]);
    cm1   = cnt - 3'd1;

    unique case (cnt[1:0])
      2'd0:    vaddr = item.corner_a;
      2'd1:    vaddr = item.corner_b;
      default: vaddr = item.corner_c;
    endcase

    faddr = (state == S_SCAN) ? k[FIDX_W-1:0] : item.face_index;

    // Cross product term order: y*z - z*y, z*x - x*z, x*y - y*x.
    unique case (cnt)
      3'd0:    begin ma = e1[1]; mb = e2[2]; end
      3'd1:    begin ma = e1[2]; mb = e2[1]; end
      3'd2:    begin ma = e1[2]; mb = e2[0]; end
      3'd3:    begin ma = e1[0]; mb = e2[2]; end
      3'd4:    begin ma = e1[0]; mb = e2[1]; end
      default: begin ma = e1[1]; mb = e2[0]; end
    endcase

    nstart = (state == S_FNORM) || (state == S_CNORM);
    for (int i = 0; i < 3; i++) begin
      if (state == S_CNORM) nvin[i] = WIDE_W'(sums[corner][i]);
      else nvin[i] = cr[i];
    end

    face_we = (state == S_FWAIT) && nstat.done;
  end

  always_ff @(posedge clk) begin
    xprod <= ma * mb;
  end

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      corner <= '0;
      iv     <= 1'b0;
      pvld   <= 1'b0;
      av     <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            item <= in_ch.payload;
            cnt  <= '0;
            if (in_ch.payload.operation == OP_LOAD_FACE) state <= S_VRD;
            else if (in_ch.payload.operation == OP_QUERY) state <= S_QHDR;
          end
        end
        S_VRD: begin
          if (cnt != 3'd0) pv[cm1[1:0]] <= vrd;
          cnt <= cnt + 3'd1;
          if (cnt == 3'd3) state <= S_EDGE;
        end
        S_EDGE: begin
          for (int i = 0; i < 3; i++) begin
            e1[i] <= 17'($signed(pv[1][i])) - 17'($signed(pv[0][i]));
            e2[i] <= 17'($signed(pv[2][i])) - 17'($signed(pv[1][i]));
          end
          cnt   <= '0;
          state <= S_CROSS;
        end
        S_CROSS: begin
          // The product of the previous step lands in its component.
          if (cnt != 3'd0) begin
            if (!cm1[0]) cr[cm1[2:1]] <= WIDE_W'(xprod);
            else cr[cm1[2:1]] <= cr[cm1[2:1]] - WIDE_W'(xprod);
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd6) state <= S_FNORM;
        end
        S_FNORM: state <= S_FWAIT;
        S_FWAIT: begin
          if (nstat.done) state <= S_IDLE;
        end
        S_QHDR: begin
          cnt <= cnt + 3'd1;
          if (cnt == 3'd1) begin
            qc <= crd;
            qn <= nrd;
            k  <= '0;
            for (int n = 0; n < 3; n++)
              for (int i = 0; i < 3; i++) sums[n][i] <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Stages in order: store read, products and matches, crease test, sum.
          iv <= issue;
          if (issue) k <= k + FCNT_W'(1);
          pvld <= iv;
          if (iv) begin
            for (int n = 0; n < 3; n++)
              occ1[n] <= 2'(crd[0] == qc[n]) + 2'(crd[1] == qc[n]) + 2'(crd[2] == qc[n]);
            for (int i = 0; i < 3; i++) dp[i] <= $signed(qn[i]) * $signed(nrd[i]);
            nrm1 <= nrd;
          end
          av <= pvld;
          if (pvld) begin
            pass2 <= (dot > thr);
            occ2  <= occ1;
            nrm2  <= nrm1;
          end
          if (av && pass2) begin
            for (int n = 0; n < 3; n++)
              for (int i = 0; i < 3; i++)
                sums[n][i] <= sums[n][i] + scale(occ2[n], nrm2[i]);
          end
          if (!issue && !iv && !pvld && !av) begin
            corner <= '0;
            state  <= S_CNORM;
          end
        end
        S_CNORM: state <= S_CWAIT;
        S_CWAIT: begin
          if (nstat.done) state <= S_OUT;
        end
        S_OUT: begin
          if (!out_ch.valid || out_ch.ready) begin
            corner <= corner + 2'd1;
            state  <= (corner == 2'd2) ? S_IDLE : S_CNORM;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register.
  logic load_out;
  assign load_out = (state == S_OUT) && (!out_ch.valid || out_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (load_out) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.payload.normal_x      <= nvout[0];
      out_ch.payload.normal_y      <= nvout[1];
      out_ch.payload.normal_z      <= nvout[2];
      out_ch.payload.queried_face  <= item.face_index;
      out_ch.payload.corner_number <= corner;
      out_ch.payload.last          <= (corner == 2'd2);
    end
  end

`ifndef NO_ASSERTIONS
  a_norm_done_expected: assert property (@(posedge clk) disable iff (rst)
    nstat.done |-> (state == S_FWAIT || state == S_CWAIT))
    else $error("normalizer finished outside a wait state");

  a_query_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ch.payload.operation == OP_QUERY) |=> (state == S_QHDR && cnt == 3'd0))
    else $error("query did not start with the header read");

  a_out_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(state) == S_OUT)
    else $error("result appeared without the output step");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (k <= lim))
    else $error("face scan ran past the face count");
`endif

endmodule
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
module tb_top;
  import cavn_pkg::*;

  typedef longint sum_vec_t [3];
  typedef logic signed [NRM_W-1:0] unit_vec_t [3];

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_index = REG_FACE_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cavn_in_if  in_ch ();
  cavn_out_if out_ch ();

  crease_angle_vertex_normals dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Shadow copy of the block's stores and registers. It is updated at the
  // rising edge at which a request or a register write is taken; a face load
  // reaches the hardware's face stores only once its normal is done.
  logic signed [POS_W-1:0] vert_pos [VERTS][3];
  logic [VIDX_W-1:0]       face_corners [FACES][3];
  logic signed [NRM_W-1:0] face_nrm [FACES][3];
  int unsigned             face_count_reg;
  int                      crease_reg;

  // Requests waiting to be sent, and the corner normals still owed by the block.
  in_item_t  pending_requests [$];
  out_item_t expected_corners [$];

  // What the stimulus generator knows has been written so far. Queries and
  // face loads only ever touch entries that were written.
  logic [VIDX_W-1:0] known_verts [$];
  logic [FIDX_W-1:0] known_faces [$];
  bit                face_written [FACES];
  int unsigned       face_prefix;

  int  send_idle = 31;
  int  recv_idle = 54;
  bit  req_taken = 1'b0;
  int  error_count = 0;
  int  quiet_cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scale a vector to unit length in Q1.14, rounding half up. Very long
  // vectors are first shifted down so that the squares stay in 64 bits.
  function automatic unit_vec_t to_unit(sum_vec_t v);
    longint unsigned mag [3];
    longint unsigned top, sq, len, q;
    int s;
    unit_vec_t o;
    top = 0;
    sq = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = v[i] < 0 ? -v[i] : v[i];
      if (mag[i] > top) top = mag[i];
    end
    while (s < 63 && (top >> s) >= (64'd1 << 30)) s++;
    for (int i = 0; i < 3; i++) begin
      mag[i] >>= s;
      sq += mag[i] * mag[i];
    end
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = len == 0 ? 0 : (mag[i] * 32768 + len) / (2 * len);
      o[i] = v[i] < 0 ? NRM_W'(-longint'(q)) : NRM_W'(longint'(q));
    end
    return o;
  endfunction

  // Update the shadow stores for one taken request and queue the corner
  // normals that a query owes.
  function automatic void apply_request(in_item_t r);
    longint p [3][3];
    longint e1 [3], e2 [3];
    sum_vec_t c, acc;
    unit_vec_t u;
    out_item_t res;
    logic [VIDX_W-1:0] v;
    longint thr, dot, occ;
    int unsigned lim;
    case (r.operation)
      OP_LOAD_VERTEX: begin
        vert_pos[r.vertex_index][0] = r.pos_x;
        vert_pos[r.vertex_index][1] = r.pos_y;
        vert_pos[r.vertex_index][2] = r.pos_z;
      end
      OP_LOAD_FACE: begin
        for (int i = 0; i < 3; i++) begin
          p[0][i] = vert_pos[r.corner_a][i];
          p[1][i] = vert_pos[r.corner_b][i];
          p[2][i] = vert_pos[r.corner_c][i];
        end
        for (int i = 0; i < 3; i++) begin
          e1[i] = p[1][i] - p[0][i];
          e2[i] = p[2][i] - p[1][i];
        end
        c[0] = e1[1] * e2[2] - e1[2] * e2[1];
        c[1] = e1[2] * e2[0] - e1[0] * e2[2];
        c[2] = e1[0] * e2[1] - e1[1] * e2[0];
        u = to_unit(c);
        face_corners[r.face_index][0] = r.corner_a;
        face_corners[r.face_index][1] = r.corner_b;
        face_corners[r.face_index][2] = r.corner_c;
        for (int i = 0; i < 3; i++) face_nrm[r.face_index][i] = u[i];
      end
      OP_QUERY: begin
        thr = longint'(crease_reg) * 16384;
        lim = face_count_reg < FACES ? face_count_reg : FACES;
        for (int n = 0; n < 3; n++) begin
          acc = '{0, 0, 0};
          v = face_corners[r.face_index][n];
          for (int unsigned k = 0; k < lim; k++) begin
            occ = (face_corners[k][0] == v) + (face_corners[k][1] == v) +
                  (face_corners[k][2] == v);
            if (occ != 0) begin
              dot = 0;
              for (int i = 0; i < 3; i++)
                dot += longint'(face_nrm[r.face_index][i]) * longint'(face_nrm[k][i]);
              if (dot > thr)
                for (int i = 0; i < 3; i++) acc[i] += occ * longint'(face_nrm[k][i]);
            end
          end
          u = to_unit(acc);
          res.normal_x = u[0];
          res.normal_y = u[1];
          res.normal_z = u[2];
          res.queried_face = r.face_index;
          res.corner_number = n[1:0];
          res.last = n == 2;
          expected_corners.push_back(res);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      error_count++;
    end
  endfunction

  // Every field starts random, so bits that the operation ignores still
  // toggle; callers then set the fields that matter.
  function automatic in_item_t random_request(logic [1:0] op);
    logic [127:0] bits;
    in_item_t r;
    bits = {$urandom, $urandom, $urandom, $urandom};
    r = bits[$bits(in_item_t)-1:0];
    r.operation = op;
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] random_coord();
    case ($urandom_range(5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      default: return POS_W'($urandom);
    endcase
  endfunction

  task automatic add_vertex(logic [VIDX_W-1:0] idx, logic signed [POS_W-1:0] x,
                            logic signed [POS_W-1:0] y, logic signed [POS_W-1:0] z);
    in_item_t r;
    r = random_request(OP_LOAD_VERTEX);
    r.vertex_index = idx;
    r.pos_x = x;
    r.pos_y = y;
    r.pos_z = z;
    known_verts.push_back(idx);
    pending_requests.push_back(r);
  endtask

  task automatic add_face(logic [FIDX_W-1:0] slot, logic [VIDX_W-1:0] a,
                          logic [VIDX_W-1:0] b, logic [VIDX_W-1:0] c);
    in_item_t r;
    r = random_request(OP_LOAD_FACE);
    r.face_index = slot;
    r.corner_a = a;
    r.corner_b = b;
    r.corner_c = c;
    if (!face_written[slot]) known_faces.push_back(slot);
    face_written[slot] = 1'b1;
    while (face_prefix < FACES && face_written[face_prefix]) face_prefix++;
    pending_requests.push_back(r);
  endtask

  task automatic add_query(logic [FIDX_W-1:0] slot);
    in_item_t r;
    r = random_request(OP_QUERY);
    r.face_index = slot;
    pending_requests.push_back(r);
  endtask

  function automatic logic [VIDX_W-1:0] any_vertex();
    return known_verts[$urandom_range(known_verts.size() - 1)];
  endfunction

  // Wait until every request went out and every corner normal came back, then
  // give the block time to finish a face load, which owes no result.
  task automatic settle();
    do @(posedge clk);
    while (pending_requests.size() != 0 || in_ch.valid || expected_corners.size() != 0);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_DATA_W-1:0] val);
    settle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One stretch of random traffic. Most of it is well-formed: faces built
  // from loaded vertices and queries of loaded faces, with face slots mostly
  // extending the loaded run from slot 0 so that the scan sees real faces.
  task automatic random_traffic(int count);
    int pick;
    for (int j = 0; j < count; j++) begin
      pick = $urandom_range(99);
      if (pick < 22) begin
        add_vertex(VIDX_W'($urandom), random_coord(), random_coord(), random_coord());
      end else if (pick < 50) begin
        if ($urandom_range(2) != 0 && face_prefix < FACES)
          add_face(FIDX_W'(face_prefix), any_vertex(), any_vertex(), any_vertex());
        else if ($urandom_range(1) == 0)
          add_face(FIDX_W'($urandom), any_vertex(), any_vertex(), any_vertex());
        else
          add_face(FIDX_W'($urandom_range(face_prefix)), any_vertex(), any_vertex(),
                   any_vertex());
      end else if (pick < 95) begin
        add_query(known_faces[$urandom_range(known_faces.size() - 1)]);
      end else begin
        pending_requests.push_back(random_request(2'd3));
      end
    end
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_crease();
    case ($urandom_range(4))
      0: return -16'sd16384;
      1: return 16'sd16384;
      default: return CFG_DATA_W'($urandom_range(32768) - 16384);
    endcase
  endfunction

  // Registers and stores are shadowed at the edge that takes a write or a
  // request; results are checked in order against the oldest expectation.
  always @(posedge clk) begin
    out_item_t got, want;
    req_taken = in_ch.valid && in_ch.ready && !rst;
    if (rst) begin
      face_count_reg = 0;
      crease_reg = CREASE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_FACE_COUNT) face_count_reg = cfg_data[FCNT_W-1:0];
      else crease_reg = $signed(cfg_data);
    end
    if (req_taken) apply_request(in_ch.payload);
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.payload;
      if (expected_corners.size() == 0) begin
        $display("%0t: unexpected corner normal, expected none, actual %p", $time, got);
        error_count++;
      end else begin
        want = expected_corners.pop_front();
        check_field("normal_x", want.normal_x, got.normal_x);
        check_field("normal_y", want.normal_y, got.normal_y);
        check_field("normal_z", want.normal_z, got.normal_z);
        check_field("queried_face", want.queried_face, got.queried_face);
        check_field("corner_number", want.corner_number, got.corner_number);
        check_field("last", want.last, got.last);
      end
    end
  end

  // Request driver and result back-pressure, both moved at the falling edge.
  always @(negedge clk) begin
    in_item_t nxt;
    logic go;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || req_taken) begin
      go = pending_requests.size() != 0 && $urandom_range(99) >= send_idle;
      if (go) begin
        nxt = pending_requests.pop_front();
        in_ch.payload <= nxt;
      end
      in_ch.valid <= go;
    end
    out_ch.ready <= !rst && $urandom_range(99) >= recv_idle;
  end

  // A query over all 4096 faces with stalls on its results stays well below
  // this limit; nothing taken for this long means the block hung.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 50000) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    face_prefix = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. A flat triangle and its mirror image, a face that uses
    // the extreme corner of the coordinate range, a degenerate face with a
    // repeated vertex, and a face in the top slot. With the reset face count
    // of zero nothing is scanned, so the first query gives zero normals.
    add_vertex(12'd0, 16'sd0, 16'sd0, 16'sd0);
    add_vertex(12'd1, 16'sh7FFF, 16'sd0, 16'sd0);
    add_vertex(12'd2, 16'sd0, 16'sh7FFF, 16'sd0);
    add_vertex(12'hFFF, 16'sh8000, 16'sh8000, 16'sh8000);
    add_vertex(12'd3, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    add_face(12'd0, 12'd0, 12'd1, 12'd2);
    add_face(12'd1, 12'd0, 12'd2, 12'd1);
    add_face(12'd2, 12'd0, 12'd1, 12'hFFF);
    add_face(12'd3, 12'd0, 12'd0, 12'd1);
    add_face(12'd4, 12'd3, 12'hFFF, 12'd1);
    add_face(12'hFFF, 12'hFFF, 12'd1, 12'd2);
    pending_requests.push_back(random_request(2'd3));
    add_query(12'd0);

    // Scan the first five faces: a query of a scanned face, of the
    // degenerate face, and of a face beyond the scanned range.
    write_reg(REG_FACE_COUNT, 16'd5);
    add_query(12'd0);
    add_query(12'd3);
    add_query(12'hFFF);
    // Lowest threshold lets every face but an exact opposite through.
    write_reg(REG_CREASE, -16'sd16384);
    add_query(12'd0);
    add_query(12'd2);
    // Highest threshold can never be exceeded, so every sum is zero.
    write_reg(REG_CREASE, 16'sd16384);
    add_query(12'd4);

    // Random part in three idling modes, two register settings each.
    for (int mode = 0; mode < 3; mode++) begin
      send_idle = mode == 0 ? 31 : (mode == 1 ? 54 : 0);
      recv_idle = mode == 0 ? 54 : (mode == 1 ? 31 : 0);
      for (int half = 0; half < 2; half++) begin
        write_reg(REG_FACE_COUNT, half == 0 ? CFG_DATA_W'(face_prefix) :
                                  CFG_DATA_W'($urandom_range(face_prefix)));
        write_reg(REG_CREASE, random_crease());
        random_traffic(20);
      end
    end

    // Scan the whole loaded run from slot 0 once more.
    write_reg(REG_FACE_COUNT, CFG_DATA_W'(face_prefix));
    write_reg(REG_CREASE, random_crease());
    add_query(12'd0);
    add_query(known_faces[$urandom_range(known_faces.size() - 1)]);

    settle();
    if (error_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
rtl/cavn_pkg.sv
rtl/cavn_if.sv
rtl/cavn_norm.sv
rtl/crease_angle_vertex_normals.sv
tb/tb_top.sv
